// ===== sv/bce_pkg.sv =====
// ----------------------------------------------------------------------------
// bce_pkg: shared types and constants for the binary cross-entropy block
// Field widths, fixed-point constants and the queue entry format.
// ----------------------------------------------------------------------------
package bce_pkg;

   localparam int PW = 16;
   localparam int EPS_W = 14;
   localparam int SCALE_W = 33;
   localparam int GRAD_W = 40;
   localparam int LOSS_W = 28;
   localparam int SUM_W = 52;
   localparam int DEF_MAX_ELEMENTS = 1048576;

   localparam logic [15:0] ONE_Q15 = 16'd32768;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   localparam int CSR_EPSILON = 0;
   localparam int CSR_GRAD_SCALE = 1;

   // classified element handed from the front part to the back part
   typedef struct packed {
      logic [15:0] p;      // clamped prediction
      logic [15:0] q;      // 1 - p
      logic [15:0] t;      // truth, clamped to one
      logic        neg;    // truth above prediction
      logic [15:0] diff;   // |p - t|
      logic        last;
   } item_type;

   // -ln(x/32768) stage helpers
   function automatic logic [3:0] msb_pos(input logic [15:0] x);
      logic [3:0] k;
      k = 4'd0;
      for (int i = 1; i < 16; i++) begin
         if (x[i]) k = 4'(i);
      end
      return k;
   endfunction

endpackage

// ===== sv/bce_front.sv =====
// ----------------------------------------------------------------------------
// bce_front: input stage
// Accepts an item, clamps prediction and truth, and forms the difference.
// ----------------------------------------------------------------------------
module bce_front
   import bce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [15:0]       req_prediction,
   input  logic [15:0]       req_truth,
   input  logic              req_last,
   input  logic [EPS_W-1:0]  eps,
   output logic              q_valid,
   input  logic              q_ready,
   output item_type          q_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic [15:0] e, t, p, hi;

   // classify the incoming element
   always_comb begin
      e = (eps == '0) ? 16'd1 : {2'b00, eps};
      t = (req_truth > ONE_Q15) ? ONE_Q15 : req_truth;
      hi = ONE_Q15 - e;
      if (req_prediction > hi) p = hi;
      else if (req_prediction < e) p = e;
      else p = req_prediction;
      item_in.p = p;
      item_in.q = ONE_Q15 - p;
      item_in.t = t;
      item_in.neg = t > p;
      item_in.diff = (t > p) ? (t - p) : (p - t);
      item_in.last = req_last;
   end

   assign req_stall = valid_ff && !q_ready;
   assign q_valid = valid_ff;
   assign q_item = item_ff;

   // hold until the queue takes the entry
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && !req_stall) item_ff <= item_in;
   end

   always_comb begin
      valid_in = valid_ff;
      if (q_ready) valid_in = 1'b0;
      if (req_valid && !req_stall) valid_in = 1'b1;
   end

endmodule

// ===== sv/bce_queue.sv =====
// ----------------------------------------------------------------------------
// bce_queue: decoupling queue
// Small FIFO between the classifier and the arithmetic sequencer.
// ----------------------------------------------------------------------------
module bce_queue
   import bce_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  item_type wr_item,
   output logic     rd_valid,
   input  logic     rd_ready,
   output item_type rd_item
);

   item_type mem_ff [2];
   logic     wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic     wr, rd;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_item = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   // advance pointers on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) mem_ff[wp_ff] <= wr_item;
   end

endmodule

// ===== sv/bce_back.sv =====
// ----------------------------------------------------------------------------
// bce_back: arithmetic sequencer
// Computes log terms by squaring steps, gradient by restoring division,
// accumulates the loss and forms the mean on the last element.
// ----------------------------------------------------------------------------
module bce_back
   import bce_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  item_type              in_item,
   input  logic [SCALE_W-1:0]    scale,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [GRAD_W-1:0]     rsp_gradient,
   output logic [LOSS_W-1:0]     rsp_loss,
   output logic                  rsp_loss_valid
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_MUL   = 9'b000000010,
      S_DIV   = 9'b000000100,
      S_LOG   = 9'b000001000,
      S_LN    = 9'b000010000,
      S_ELEM  = 9'b000100000,
      S_MEAN  = 9'b001000000,
      S_MEAN2 = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;
   item_type    it_ff;
   logic [5:0]  cnt_ff;
   logic        sel_ff;          // 0: log of p, 1: log of q
   // division
   logic [31:0] d_ff;
   logic [55:0] num_ff;          // diff*scale*128 + d/2
   logic [55:0] quo_ff;
   logic [32:0] rem_ff;
   // log
   logic [32:0] m_ff;
   logic [3:0]  k_ff;
   logic [23:0] frac_ff;
   logic [27:0] lnp_ff, lnq_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [63:0] h_ff, a_ff;
   logic [GRAD_W-1:0] grad_ff;
   logic [LOSS_W-1:0] loss_ff;
   logic        lv_ff;

   logic [65:0] msq;
   logic [32:0] m_nx;
   logic [33:0] rem_sh;
   logic [28:0] n2;
   logic [60:0] lnw;
   logic [43:0] t1, t2;
   logic [44:0] elem_w;
   logic [28:0] elem;
   logic [52:0] sum_w;
   logic [63:0] hs, rest;
   logic [64:0] tot;

   assign in_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_OUT;
   assign rsp_gradient = grad_ff;
   assign rsp_loss = loss_ff;
   assign rsp_loss_valid = lv_ff;

   // datapath of one step
   always_comb begin
      msq = 66'(m_ff) * 66'(m_ff);
      m_nx = 33'(msq >> 30);
      rem_sh = {rem_ff, num_ff[55]};
      n2 = 29'((15 << 24)) - {1'b0, k_ff, frac_ff};
      lnw = 61'(n2) * 61'(LN2_Q32) + 61'(64'h80000000);
      t1 = 44'(it_ff.t) * 44'(lnp_ff);
      t2 = 44'(ONE_Q15 - it_ff.t) * 44'(lnq_ff);
      elem_w = 45'(t1) + 45'(t2) + 45'd16384;
      elem = elem_w[43:15];
      sum_w = 53'(sum_ff) + 53'(elem);
      hs = h_ff >> 6;
      rest = (({58'd0, h_ff[5:0]} << 26) + a_ff) >> 32;
      tot = 65'(hs) + 65'(rest);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (in_valid) state_in = S_MUL;
         S_MUL:   state_in = S_DIV;
         S_DIV:   if (cnt_ff == 6'd55) state_in = S_LOG;
         S_LOG:   if (cnt_ff == 6'd23) state_in = S_LN;
         S_LN:    if (sel_ff) state_in = S_ELEM; else state_in = S_LOG;
         S_ELEM:  state_in = it_ff.last ? S_MEAN : S_OUT;
         S_MEAN:  state_in = S_MEAN2;
         S_MEAN2: state_in = S_OUT;
         S_OUT:   if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sum_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_ELEM) begin
            sum_ff <= sum_w[52] ? {SUM_W{1'b1}} : sum_w[SUM_W-1:0];
         end
         if (state_ff == S_MEAN2) sum_ff <= '0;
      end
      unique case (state_ff)
         S_IDLE: begin
            it_ff <= in_item;
            d_ff <= 32'(in_item.p) * 32'(in_item.q);
            cnt_ff <= '0;
            sel_ff <= 1'b0;
            lv_ff <= 1'b0;
            loss_ff <= '0;
         end
         S_MUL: begin
            // diff*scale fits in 49 bits; shift by 7 and add half divisor
            num_ff <= ((56'(it_ff.diff) * 56'(scale)) << 7) + 56'(d_ff >> 1);
            rem_ff <= '0;
            quo_ff <= '0;
         end
         S_DIV: begin
            // one restoring step a cycle
            if (rem_sh >= 34'(d_ff)) begin
               rem_ff <= 33'(rem_sh - 34'(d_ff));
               quo_ff <= {quo_ff[54:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[32:0];
               quo_ff <= {quo_ff[54:0], 1'b0};
            end
            num_ff <= num_ff << 1;
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd55) begin
               cnt_ff <= '0;
               k_ff <= msb_pos(it_ff.p);
               m_ff <= 33'(it_ff.p) << (5'd30 - 5'(msb_pos(it_ff.p)));
               frac_ff <= '0;
            end
         end
         S_LOG: begin
            // one squaring step a cycle
            if (m_nx[31]) begin
               m_ff <= m_nx >> 1;
               frac_ff <= {frac_ff[22:0], 1'b1};
            end else begin
               m_ff <= m_nx;
               frac_ff <= {frac_ff[22:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 6'd1;
         end
         S_LN: begin
            cnt_ff <= '0;
            if (!sel_ff) begin
               lnp_ff <= lnw[59:32];
               sel_ff <= 1'b1;
               k_ff <= msb_pos(it_ff.q);
               m_ff <= 33'(it_ff.q) << (5'd30 - 5'(msb_pos(it_ff.q)));
               frac_ff <= '0;
            end else begin
               lnq_ff <= lnw[59:32];
            end
            // saturate gradient
            if (it_ff.neg) begin
               grad_ff <= (quo_ff > 56'(64'h8000000000)) ? 40'h8000000000
                        : 40'(56'd0 - quo_ff);
            end else begin
               grad_ff <= (quo_ff > 56'(64'h7FFFFFFFFF)) ? 40'h7FFFFFFFFF
                        : quo_ff[39:0];
            end
         end
         S_ELEM: begin
            lv_ff <= it_ff.last;
         end
         S_MEAN: begin
            h_ff <= 64'(sum_ff >> 26) * 64'(scale);
            a_ff <= 64'(sum_ff[25:0]) * 64'(scale) + 64'h80000000;
         end
         S_MEAN2: begin
            loss_ff <= (tot > 65'(28'hFFFFFFF)) ? 28'hFFFFFFF : tot[27:0];
         end
         S_OUT: begin
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== sv/binary_cross_entropy_loss_grad.sv =====
// ----------------------------------------------------------------------------
// binary_cross_entropy_loss_grad: streamed BCE loss and gradient
// Front classifier, two-entry queue and an arithmetic sequencer.
// ----------------------------------------------------------------------------
// In the back sequencer each element runs 56 restoring division steps for the
// gradient and two 24-step squaring runs for the logarithms, with the setup
// states S_MUL, S_LN and S_ELEM around them and, on the last element, S_MEAN
// and S_MEAN2 for the mean. The front stage and queue take the next elements meanwhile.
module binary_cross_entropy_loss_grad
   import bce_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_prediction,
   input  logic [15:0]        req_truth,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [GRAD_W-1:0]  rsp_gradient,
   output logic [LOSS_W-1:0]  rsp_loss,
   output logic               rsp_loss_valid,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [SCALE_W-1:0] csr_data
);

   logic [EPS_W-1:0]   eps_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic     fq_valid, fq_ready, qb_valid, qb_ready;
   item_type fq_item, qb_item;

   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 14'd1;
         scale_ff <= 33'h100000000;
      end else if (csr_valid) begin
         if (csr_index == 1'(CSR_EPSILON)) eps_ff <= csr_data[EPS_W-1:0];
         else scale_ff <= csr_data;
      end
   end

   bce_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_prediction, .req_truth,
      .req_last, .eps(eps_ff), .q_valid(fq_valid), .q_ready(fq_ready),
      .q_item(fq_item)
   );

   bce_queue u_queue (
      .clock, .reset, .wr_valid(fq_valid), .wr_ready(fq_ready),
      .wr_item(fq_item), .rd_valid(qb_valid), .rd_ready(qb_ready),
      .rd_item(qb_item)
   );

   bce_back u_back (
      .clock, .reset, .in_valid(qb_valid), .in_ready(qb_ready),
      .in_item(qb_item), .scale(scale_ff), .rsp_valid, .rsp_stall,
      .rsp_gradient, .rsp_loss, .rsp_loss_valid
   );

   // a loss is only reported on the result that ends a batch
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_loss_valid |-> rsp_loss == '0)
      else $error("loss reported off a batch end");

   // a stalled response holds its gradient
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gradient))
      else $error("response changed while stalled");

   // the front stalls only while its stage holds an entry for the queue
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> fq_valid)
      else $error("front stalled with empty stage");

endmodule

// ===== test/binary_cross_entropy_loss_grad_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_cross_entropy_loss_grad_tb: self-checking bench for the BCE block
// Streams prediction/truth pairs through the block with random idling on both
// channels, predicts every gradient and batch mean loss in fixed point and
// compares each result transfer field by field.
// ----------------------------------------------------------------------------
module binary_cross_entropy_loss_grad_tb
   import bce_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_TAIL = 200;
   localparam int LONG_HOLD = 400;
   localparam logic [SCALE_W-1:0] SCALE_ONE = 33'h1_0000_0000;
   localparam logic [SCALE_W-1:0] SCALE_MAX = 33'h1_FFFF_FFFF;
   localparam logic [EPS_W-1:0] EPS_MAX = 14'h3FFF;
   localparam logic [LOSS_W-1:0] MEAN_MAX = '1;
   localparam logic [SUM_W-1:0] SUM_FULL = '1;

   typedef struct {
      logic [GRAD_W-1:0] gradient;
      logic [LOSS_W-1:0] loss;
      logic              loss_valid;
   } bce_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [15:0]        req_prediction;
   logic [15:0]        req_truth;
   logic               req_last;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [GRAD_W-1:0]  rsp_gradient;
   logic [LOSS_W-1:0]  rsp_loss;
   logic               rsp_loss_valid;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_index;
   logic [SCALE_W-1:0] csr_data;

   // predictor state and configuration
   logic [EPS_W-1:0]   clip_eps;
   logic [SCALE_W-1:0] scale_q132;
   logic [SUM_W-1:0]   batch_loss_sum;
   bce_result_type     pending_results[$];

   int errors = 0;
   int items_sent = 0;
   int batches_closed = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   bit idling_on = 1;
   int hold_ask = 0;
   int hold_done = 0;
   int hold_count = 0;
   int stall_count = 0;

   binary_cross_entropy_loss_grad dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // -ln(x/32768) in Q.24 by log2 squaring, times ln2
   function automatic logic [63:0] neg_ln_q24(input logic [15:0] x);
      logic [63:0] m, frac, n2;
      int k;
      k = 0;
      frac = 0;
      for (int i = 1; i < 16; i++) begin
         if ((x >> i) != 0) k = i;
      end
      m = 64'(x) << (30 - k);
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      n2 = (64'd15 << 24) - ((64'(k) << 24) | frac);
      return (n2 * 64'(LN2_Q32) + 64'h8000_0000) >> 32;
   endfunction

   // compute the expected result of one element and advance the loss sum
   function automatic bce_result_type bce_predict(input logic [15:0] pred,
                                                  input logic [15:0] truth,
                                                  input logic last);
      bce_result_type r;
      logic [15:0] e, p, q, t, diff;
      logic [63:0] d, mag, elem;
      logic [127:0] wide;
      logic neg;
      e = (clip_eps == 0) ? 16'd1 : 16'(clip_eps);
      t = (truth > ONE_Q15) ? ONE_Q15 : truth;
      p = pred;
      if (p > ONE_Q15 - e) p = ONE_Q15 - e;
      else if (p < e) p = e;
      q = ONE_Q15 - p;
      neg = t > p;
      diff = neg ? t - p : p - t;
      d = 64'(p) * 64'(q);
      mag = (64'(diff) * 64'(scale_q132) * 64'd128 + d / 2) / d;
      if (neg) begin
         if (mag > (64'd1 << 39)) mag = 64'd1 << 39;
         r.gradient = GRAD_W'(-mag);
      end else begin
         if (mag > (64'd1 << 39) - 1) mag = (64'd1 << 39) - 1;
         r.gradient = GRAD_W'(mag);
      end
      elem = (64'(t) * neg_ln_q24(p) + 64'(ONE_Q15 - t) * neg_ln_q24(q) + 64'd16384) >> 15;
      if (64'(batch_loss_sum) > 64'(SUM_FULL) - elem) batch_loss_sum = SUM_FULL;
      else batch_loss_sum = batch_loss_sum + SUM_W'(elem);
      r.loss = '0;
      r.loss_valid = last;
      if (last) begin
         wide = (128'(batch_loss_sum) * 128'(scale_q132) + 128'h8000_0000) >> 32;
         r.loss = (wide > 128'(MEAN_MAX)) ? MEAN_MAX : LOSS_W'(wide);
         batch_loss_sum = '0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
      errors++;
   endtask

   // offer one element until transferred, then maybe idle for a burst
   task automatic send_item(input logic [15:0] pred, input logic [15:0] truth,
                            input logic last);
      req_valid <= 1'b1;
      req_prediction <= pred;
      req_truth <= truth;
      req_last <= last;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      pending_results.push_back(bce_predict(pred, truth, last));
      items_sent++;
      if (last) batches_closed++;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write both registers back to back while the block is idle
   task automatic set_config(input logic [SCALE_W-1:0] eps_word,
                             input logic [SCALE_W-1:0] scale);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= 1'(CSR_EPSILON);
      csr_data <= eps_word;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      clip_eps = eps_word[EPS_W-1:0];
      csr_index <= 1'(CSR_GRAD_SCALE);
      csr_data <= scale;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      scale_q132 = scale;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] rand_prob();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return ONE_Q15;
         2: return 16'd0;
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   function automatic logic [15:0] rand_truth();
      case ($urandom_range(0, 9))
         0, 1, 2: return 16'd0;
         3, 4, 5: return ONE_Q15;
         6: return 16'($urandom);
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   task automatic test_defaults();
      send_item(16'd16384, 16'd0, 1'b0);
      send_item(16'd8192, ONE_Q15, 1'b0);
      send_item(16'd24576, 16'd12000, 1'b1);
   endtask

   task automatic test_extremes();
      // full-width data words: upper bits of the epsilon write are ignored
      set_config(SCALE_MAX & ~33'(EPS_MAX) | 33'd1, SCALE_ONE);
      send_item(16'd0, 16'd0, 1'b0);
      send_item(ONE_Q15, ONE_Q15, 1'b0);
      send_item(16'd0, ONE_Q15, 1'b0);
      send_item(ONE_Q15, 16'd0, 1'b1);
      // prediction and truth above one
      send_item(16'hFFFF, 16'hFFFF, 1'b0);
      send_item(16'hFFFF, 16'd0, 1'b0);
      send_item(16'd1, 16'hFFFF, 1'b1);
      // zero epsilon acts as one
      set_config(33'd0, SCALE_MAX);
      send_item(16'd0, 16'hAAAA, 1'b0);
      send_item(16'h5555, 16'd32767, 1'b1);
      // widest clip margin
      set_config(33'(EPS_MAX), 33'd1);
      send_item(16'd0, ONE_Q15, 1'b0);
      send_item(ONE_Q15, 16'd0, 1'b1);
      // zero scale gives zero gradient and zero mean
      set_config(33'd100, 33'd0);
      send_item(16'd300, ONE_Q15, 1'b0);
      send_item(16'd30000, 16'd0, 1'b1);
   endtask

   task automatic test_mean_saturation();
      // confident wrong answers push the mean past its ceiling
      set_config(33'd1, SCALE_ONE);
      send_item(16'd1, ONE_Q15, 1'b0);
      send_item(ONE_Q15, 16'd0, 1'b0);
      send_item(16'd0, ONE_Q15, 1'b1);
   endtask

   task automatic test_backpressure();
      hold_ask <= hold_ask + 1;
      repeat (30) send_item(rand_prob(), rand_truth(), $urandom_range(0, 7) == 0);
      send_item(rand_prob(), rand_truth(), 1'b1);
   endtask

   task automatic test_random_phases();
      logic [SCALE_W-1:0] eps_word, scale;
      int batch_len;
      for (int phase = 0; phase < 7; phase++) begin
         eps_word = {1'($urandom), 32'($urandom)};
         case ($urandom_range(0, 4))
            0: eps_word[EPS_W-1:0] = 14'd1;
            1: eps_word[EPS_W-1:0] = EPS_MAX;
            2: eps_word[EPS_W-1:0] = 14'($urandom_range(1, 64));
            default: ;
         endcase
         case ($urandom_range(0, 5))
            0: scale = SCALE_ONE;
            1: scale = SCALE_MAX;
            2: scale = {1'($urandom), 32'($urandom)};
            default: scale = SCALE_ONE / $urandom_range(1, 64);
         endcase
         set_config(eps_word, scale);
         if (phase == 6) idling_on = 0;
         for (int n = 0; n < 85; ) begin
            batch_len = $urandom_range(1, 16);
            for (int j = 0; j < batch_len; j++) begin
               send_item(rand_prob(), rand_truth(), j == batch_len - 1);
               n++;
            end
         end
      end
   endtask

   // result side: check every transfer, drive stall bursts and the long hold
   always @(posedge clock) begin
      bce_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", 64'd1, 64'd0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_gradient !== want.gradient)
                  report_mismatch("gradient", 64'(rsp_gradient), 64'(want.gradient));
               if (rsp_loss !== want.loss)
                  report_mismatch("loss", 64'(rsp_loss), 64'(want.loss));
               if (rsp_loss_valid !== want.loss_valid)
                  report_mismatch("loss_valid", 64'(rsp_loss_valid), 64'(want.loss_valid));
            end
         end
         if (hold_ask != hold_done) begin
            hold_done <= hold_ask;
            hold_count <= LONG_HOLD;
            rsp_stall <= 1'b1;
         end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            rsp_stall <= 1'b1;
         end else if (stall_count > 0) begin
            stall_count <= stall_count - 1;
            rsp_stall <= 1'b1;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_count <= $urandom_range(0, 9);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: end the run when no channel transfers for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_results.size());
         $display("binary_cross_entropy_loss_grad_tb: done, errors");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_prediction = '0;
      req_truth = '0;
      req_last = 1'b0;
      csr_valid = 1'b0;
      csr_index = 1'b0;
      csr_data = '0;
      clip_eps = 14'd1;
      scale_q132 = SCALE_ONE;
      batch_loss_sum = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults();
      test_extremes();
      test_mean_saturation();
      test_backpressure();
      test_random_phases();

      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      $display("covered %0d elements in %0d batches, %0d results checked", items_sent,
               batches_closed, results_seen);
      $display("configs: clip margins 0/1/max/random, scales 0/1/one/max/random, long hold");
      if (errors == 0 && pending_results.size() == 0) begin
         $display("binary_cross_entropy_loss_grad_tb: done, clean");
      end else begin
         $display("binary_cross_entropy_loss_grad_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/bce_pkg.sv
sv/bce_front.sv
sv/bce_queue.sv
sv/bce_back.sv
sv/binary_cross_entropy_loss_grad.sv
test/binary_cross_entropy_loss_grad_tb.sv
